// ----- sv/ptbs_pkg.sv -----
`timescale 1ns / 1ps

package ptbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Sentinel metric for an unknown link
    localparam logic signed [15:0] METRIC_UNKNOWN = 16'sd1;

    // Table action codes
    typedef enum logic [1:0] {
        ACT_UPDATED  = 2'd0,
        ACT_INSERTED = 2'd1,
        ACT_DROPPED  = 2'd2
    } action_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic        [15:0] addr;
        logic signed [15:0] metric;
    } entry_t;

endpackage

// ----- sv/parent_table_best_select.sv -----
`timescale 1ns / 1ps

// Neighbor table with best-parent selection.
// Input: pulse start with neighbor_addr and link_metric while busy is low;
// the beat is taken at that rising edge and busy rises on the next cycle.
// Output: done is high for exactly one cycle with best_parent_addr,
// best_parent_metric, table_action and entry_count; the receiver cannot
// stall, so the result must be captured in that cycle. busy falls in the
// same cycle that done rises, so the next beacon can be taken at the edge
// that ends the done cycle.
// Operation: the table lives in one synchronous memory (one read port,
// one write port, registered read data). Each beacon reads all stored
// entries from newest to oldest, one per cycle, matching the address and
// tracking the best metric in the same pass; the finish state writes back
// the updated or inserted entry and folds in a newly inserted entry.
// Busy and throughput: busy stays high through the scan of all stored
// entries and the finish state (only the finish state on an empty table),
// set by the single memory read port; done follows the last busy cycle,
// so a new beacon is taken only after the previous one is done.
// Reset: the entry count and the result registers clear to zero; memory
// contents are not cleared, as only entries below the count are ever read.
module parent_table_best_select (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [15:0]               neighbor_addr,
    input  logic signed [15:0]        link_metric,
    output logic                      busy,
    output logic                      done,
    output logic [15:0]               best_parent_addr,
    output logic signed [15:0]        best_parent_metric,
    output ptbs_pkg::action_t         table_action,
    output logic [3:0]                entry_count
);
    import ptbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [15:0]         in_addr_reg;
    logic signed [15:0]  in_metric_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic                issue_reg;
    logic                pend_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                have_reg;
    logic [15:0]         best_addr_reg;
    logic signed [15:0]  best_metric_reg;
    logic                done_reg;
    logic [15:0]         out_addr_reg;
    logic signed [15:0]  out_metric_reg;
    action_t             out_action_reg;
    logic [3:0]          out_count_reg;

    // Entry memory
    entry_t              mem [TABLE_DEPTH];
    entry_t              rd_data_reg;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    // Scan datapath
    logic                hit;
    logic signed [15:0]  eff_metric;
    logic                take_scan;
    logic                room;
    logic                take_new;
    logic [31:0]         fill_ext;
    action_t             action_next;

    // Read and write the entry memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_en = (state_reg == ST_SCAN) && issue_reg;

    // Match the returned entry and substitute the new metric on a hit
    assign hit        = (rd_data_reg.addr == in_addr_reg);
    assign eff_metric = hit ? in_metric_reg : rd_data_reg.metric;
    assign take_scan  = (eff_metric != METRIC_UNKNOWN)
                        && (!have_reg || (best_metric_reg < eff_metric));

    // Decide the write-back at the end of the pass
    assign room     = (fill_reg < CNT_W'(TABLE_DEPTH));
    assign take_new = !found_reg && room && (in_metric_reg != METRIC_UNKNOWN)
                      && (!have_reg || (best_metric_reg <= in_metric_reg));

    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = hit_idx_reg;
        wr_data     = '{addr: in_addr_reg, metric: in_metric_reg};
        fill_next   = fill_reg;
        action_next = ACT_DROPPED;
        if (state_reg == ST_FINISH)
        begin
            priority if (found_reg)
            begin
                wr_en       = 1'b1;
                action_next = ACT_UPDATED;
            end
            else if (room)
            begin
                wr_en       = 1'b1;
                wr_addr     = fill_reg[IDX_W-1:0];
                fill_next   = fill_reg + 1'b1;
                action_next = ACT_INSERTED;
            end
            else
            begin
                action_next = ACT_DROPPED;
            end
        end
    end

    assign fill_ext = {{(32 - CNT_W){1'b0}}, fill_next};

    // Sequence the pass and hold the result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            in_addr_reg     <= '0;
            in_metric_reg   <= '0;
            ptr_reg         <= '0;
            issue_reg       <= 1'b0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            hit_idx_reg     <= '0;
            have_reg        <= 1'b0;
            best_addr_reg   <= '0;
            best_metric_reg <= METRIC_UNKNOWN;
            done_reg        <= 1'b0;
            out_addr_reg    <= '0;
            out_metric_reg  <= '0;
            out_action_reg  <= ACT_UPDATED;
            out_count_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_FINISH);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        in_addr_reg     <= neighbor_addr;
                        in_metric_reg   <= link_metric;
                        found_reg       <= 1'b0;
                        have_reg        <= 1'b0;
                        best_addr_reg   <= '0;
                        best_metric_reg <= METRIC_UNKNOWN;
                        ptr_reg         <= IDX_W'(fill_reg - 1'b1);
                        pend_reg        <= 1'b0;
                        if (fill_reg == '0)
                        begin
                            issue_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            issue_reg <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // advance the read pointer toward the oldest entry
                    if (issue_reg)
                    begin
                        pend_reg <= 1'b1;
                        if (ptr_reg == '0)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    // fold in the entry returned by the memory
                    if (pend_reg)
                    begin
                        if (hit)
                        begin
                            found_reg   <= 1'b1;
                            hit_idx_reg <= IDX_W'(ptr_reg + (issue_reg ? 1'b1 : 1'b0));
                        end
                        if (take_scan)
                        begin
                            have_reg        <= 1'b1;
                            best_metric_reg <= eff_metric;
                            best_addr_reg   <= rd_data_reg.addr;
                        end
                        if (!issue_reg)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    fill_reg       <= fill_next;
                    out_action_reg <= action_next;
                    out_count_reg  <= fill_ext[3:0];
                    if (take_new)
                    begin
                        out_addr_reg   <= in_addr_reg;
                        out_metric_reg <= in_metric_reg;
                    end
                    else
                    begin
                        out_addr_reg   <= best_addr_reg;
                        out_metric_reg <= best_metric_reg;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the ports
    assign busy               = (state_reg != ST_IDLE);
    assign done               = done_reg;
    assign best_parent_addr   = out_addr_reg;
    assign best_parent_metric = out_metric_reg;
    assign table_action       = out_action_reg;
    assign entry_count        = out_count_reg;

endmodule

// ----- tb/sv/tb_parent_table_best_select.sv -----
`timescale 1ns / 1ps

module tb_parent_table_best_select;

    import ptbs_pkg::*;

    localparam int RANDOM_BEACONS = 400;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 6;
    localparam int MAX_REPORTS    = 10;

    // Addresses that fill the neighbor table in the directed part, oldest first
    localparam logic [15:0] FILL_ADDRS [8] = '{
        16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
        16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC
    };

    typedef struct {
        logic        [15:0] addr;
        logic signed [15:0] metric;
        int unsigned        gap;
    } beacon_t;

    typedef struct {
        logic        [15:0] addr;
        logic signed [15:0] metric;
        action_t            action;
        logic        [3:0]  count;
    } parent_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic        [15:0] neighbor_addr = 16'h0000;
    logic signed [15:0] link_metric = 16'sd0;
    logic               busy;
    logic               done;
    logic        [15:0] best_parent_addr;
    logic signed [15:0] best_parent_metric;
    action_t            table_action;
    logic        [3:0]  entry_count;

    // Predictor state: neighbor table as the block should hold it
    logic        [15:0] nb_addr [TABLE_DEPTH];
    logic signed [15:0] nb_metric [TABLE_DEPTH];
    int                 nb_fill = 0;

    beacon_t        beacon_q [$];
    parent_result_t parent_q [$];
    beacon_t        cur_beacon;
    int unsigned    idle_left = 0;
    int unsigned    idle_mode = 2;
    int             total_beacons = 0;
    int             beacons_sent = 0;
    int             errors = 0;
    int             n_updated = 0;
    int             n_inserted = 0;
    int             n_dropped = 0;
    int             n_no_parent = 0;

    parent_table_best_select dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .neighbor_addr      (neighbor_addr),
        .link_metric        (link_metric),
        .busy               (busy),
        .done               (done),
        .best_parent_addr   (best_parent_addr),
        .best_parent_metric (best_parent_metric),
        .table_action       (table_action),
        .entry_count        (entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Update the predicted table with one beacon and pick the best parent
    function automatic parent_result_t apply_beacon(input logic [15:0] addr,
                                                    input logic signed [15:0] metric);
        parent_result_t r;
        bit             found;
        bit             have_best;
        found = 1'b0;
        have_best = 1'b0;
        r.action = ACT_DROPPED;
        for (int k = 0; k < nb_fill; k++)
        begin
            if (!found && nb_addr[k] == addr)
            begin
                nb_metric[k] = metric;
                r.action = ACT_UPDATED;
                found = 1'b1;
            end
        end
        if (!found && nb_fill < TABLE_DEPTH)
        begin
            nb_addr[nb_fill] = addr;
            nb_metric[nb_fill] = metric;
            nb_fill++;
            r.action = ACT_INSERTED;
        end
        // Scan newest to oldest; strict compare keeps the newer entry on a tie
        r.addr = 16'h0000;
        r.metric = METRIC_UNKNOWN;
        for (int k = nb_fill - 1; k >= 0; k--)
        begin
            if (nb_metric[k] != METRIC_UNKNOWN && (!have_best || nb_metric[k] > r.metric))
            begin
                r.addr = nb_addr[k];
                r.metric = nb_metric[k];
                have_best = 1'b1;
            end
        end
        r.count = 4'(nb_fill);
        return r;
    endfunction

    // Draw the idle cycles ahead of one beacon for the current idle mode
    function automatic int unsigned draw_gap();
        case (idle_mode)
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // Mix sentinel, extreme, small and fully random metrics
    function automatic logic signed [15:0] draw_metric(input int unsigned unknown_pct);
        if ($urandom_range(0, 99) < unknown_pct)
            return METRIC_UNKNOWN;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    4:       return 16'sh0002;
                    default: return 16'sh4000;
                endcase
            end
            1:       return 16'(int'($urandom_range(0, 7)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_beacon(input logic [15:0] addr, input logic signed [15:0] metric);
        beacon_t b;
        b.addr = addr;
        b.metric = metric;
        b.gap = draw_gap();
        beacon_q.push_back(b);
    endtask

    // Driver: present beacons, hold them until taken, idle between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                parent_q.push_back(apply_beacon(cur_beacon.addr, cur_beacon.metric));
                beacons_sent++;
                if (beacon_q.size() > 0 && beacon_q[0].gap == 0)
                begin
                    cur_beacon = beacon_q.pop_front();
                    neighbor_addr <= cur_beacon.addr;
                    link_metric <= cur_beacon.metric;
                end
                else
                begin
                    start <= 1'b0;
                    if (beacon_q.size() > 0)
                        idle_left = beacon_q[0].gap - 1;
                end
            end
            else if (!start)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (beacon_q.size() > 0)
                begin
                    cur_beacon = beacon_q.pop_front();
                    neighbor_addr <= cur_beacon.addr;
                    link_metric <= cur_beacon.metric;
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        parent_result_t want;
        if (rst_n && done)
        begin
            if (parent_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: addr=%h metric=%0d action=%0d count=%0d",
                             best_parent_addr, best_parent_metric, table_action, entry_count);
            end
            else
            begin
                want = parent_q.pop_front();
                case (want.action)
                    ACT_UPDATED:  n_updated++;
                    ACT_INSERTED: n_inserted++;
                    default:      n_dropped++;
                endcase
                if (want.metric == METRIC_UNKNOWN)
                    n_no_parent++;
                if (best_parent_addr !== want.addr || best_parent_metric !== want.metric
                    || table_action !== want.action || entry_count !== want.count)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display(
                            "mismatch exp/act: addr %h/%h metric %0d/%0d act %0d/%0d cnt %0d/%0d",
                            want.addr, best_parent_addr, want.metric, best_parent_metric,
                            want.action, table_action, want.count, entry_count);
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #500000;
        $display("tb_parent_table_best_select failed");
        $finish;
    end

    // Build the stimulus, release reset, wait for the last result
    initial
    begin
        logic [15:0] addr;
        int          seg_left;
        int unsigned unknown_pct;

        // Empty table, address zero, ties, all-unknown with a partial table
        add_beacon(16'h0000, METRIC_UNKNOWN);
        add_beacon(16'hFFFF, 16'sh8000);
        add_beacon(16'h0000, 16'sh7FFF);
        add_beacon(16'h0001, 16'sh7FFF);
        add_beacon(16'h0000, METRIC_UNKNOWN);
        add_beacon(16'h0001, METRIC_UNKNOWN);
        add_beacon(16'hFFFF, METRIC_UNKNOWN);
        // Fill the table, with a tie between two inserts
        add_beacon(16'h8000, 16'sh0000);
        add_beacon(16'h5555, 16'shFFFF);
        add_beacon(16'hAAAA, 16'sh0000);
        add_beacon(16'h1234, 16'sh0002);
        add_beacon(16'hFEDC, 16'sh0002);
        // Full table: drops, updates and a tie between oldest and newest
        add_beacon(16'h4321, 16'sh0064);
        add_beacon(16'hFEDC, 16'sh7FFF);
        add_beacon(16'h0000, 16'sh7FFF);
        add_beacon(16'hFEDC, 16'sh8000);
        add_beacon(16'h7FFF, 16'sh0005);
        for (int k = 0; k < TABLE_DEPTH; k++)
            add_beacon(FILL_ADDRS[k], METRIC_UNKNOWN);

        // Random part in segments of varying idle pressure and sentinel density
        seg_left = 0;
        unknown_pct = 0;
        for (int n = 0; n < RANDOM_BEACONS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(12, 40);
                idle_mode = $urandom_range(0, 2);
                case ($urandom_range(0, 3))
                    0:       unknown_pct = 0;
                    1:       unknown_pct = 20;
                    2:       unknown_pct = 50;
                    default: unknown_pct = 85;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 4) == 0)
                addr = 16'($urandom);
            else
                addr = FILL_ADDRS[$urandom_range(0, TABLE_DEPTH - 1)];
            add_beacon(addr, draw_metric(unknown_pct));
        end
        total_beacons = beacon_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (beacons_sent == total_beacons && parent_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d beacons: %0d inserted, %0d updated, %0d dropped",
                 total_beacons, n_inserted, n_updated, n_dropped);
        $display("%0d results had no valid parent, %0d errors", n_no_parent, errors);
        if (errors == 0)
            $display("tb_parent_table_best_select passed");
        else
            $display("tb_parent_table_best_select failed");
        $finish;
    end

endmodule
